>>> rtl/ptd_pkg.sv
package ptd_pkg;

	localparam int NUM_TIMED_TASKS  = 14;
	localparam int NUM_EVENTS       = 4;
	localparam int TICKS_PER_SECOND = 100;
	localparam int TIME_WIDTH       = 32;

	localparam int OP_W    = 3;
	localparam int INDEX_W = 4;
	localparam int KIND_W  = 2;

	localparam int TIDX_W   = (NUM_TIMED_TASKS > 1) ? $clog2(NUM_TIMED_TASKS) : 1;
	localparam int EIDX_W   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam int NUM_SCAN = NUM_TIMED_TASKS + NUM_EVENTS;
	localparam int SCAN_W   = $clog2(NUM_SCAN);

	localparam logic [TIME_WIDTH-1:0] TICKS_1S  = TIME_WIDTH'(TICKS_PER_SECOND);
	localparam logic [TIME_WIDTH-1:0] TICKS_10S = TIME_WIDTH'(TICKS_PER_SECOND * 10);
	localparam logic [TIME_WIDTH-1:0] SECOND    = TIME_WIDTH'(TICKS_PER_SECOND);

	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_ARM    = 3'd1;
	localparam logic [OP_W-1:0] OP_DISARM = 3'd2;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
	localparam logic [OP_W-1:0] OP_RAISE  = 3'd4;

	localparam logic [KIND_W-1:0] KIND_TASK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic              accept;
		logic              step;
		logic              finish;
		logic [SCAN_W-1:0] scan_idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic held_valid;
		logic can_push;
	} dp_sts_t;

	function automatic logic boot_enable(input int i);
		logic en;
		unique case (i)
			0, 2, 3, 5, 8, 9, 13: en = 1'b1;
			default:              en = 1'b0;
		endcase
		return en;
	endfunction

	function automatic logic [TIME_WIDTH-1:0] boot_period(input int i);
		logic [TIME_WIDTH-1:0] p;
		unique case (i)
			0, 1, 3: p = TICKS_1S;
			2, 13:   p = SECOND;
			4:       p = TICKS_10S;
			default: p = TIME_WIDTH'(1);
		endcase
		return p;
	endfunction

endpackage

>>> rtl/periodic_and_event_task_dispatcher_top.sv
// Periodic and event task dispatcher. One item at a time. Arm, disarm and raise are taken
// in idle; a query is taken and then its result is released from the held register. A tick
// is taken, then the controller walks one task entry or event flag per cycle through a single
// compare and add unit, except while a new result meets a full, stalled output register,
// and then releases the final result.
// Each result is held one step so that the final one of a tick carries last.
module periodic_and_event_task_dispatcher_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ptd_pkg::OP_W-1:0]         op,
	input  logic [ptd_pkg::INDEX_W-1:0]      task_index,
	input  logic [ptd_pkg::TIME_WIDTH-1:0]   period,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ptd_pkg::KIND_W-1:0]       kind,
	output logic [ptd_pkg::INDEX_W-1:0]      task_id,
	output logic                             enabled,
	output logic                             last
);

	ptd_pkg::ctl_cmd_t cmd;
	ptd_pkg::dp_sts_t  sts;

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (op),
		.task_index (task_index),
		.period     (period),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.task_id    (task_id),
		.enabled    (enabled),
		.last       (last)
	);

endmodule

>>> rtl/ptd_ctrl.sv
module ptd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [ptd_pkg::OP_W-1:0] op,
	input  ptd_pkg::dp_sts_t       sts,
	output ptd_pkg::ctl_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]                  state_q;
	logic [ptd_pkg::SCAN_W-1:0]  cnt_q;
	logic                        blocked;

	assign in_stall     = (state_q != ST_IDLE);
	assign blocked      = sts.hit && sts.held_valid && !sts.can_push;
	assign cmd.accept   = in_valid && (state_q == ST_IDLE);
	assign cmd.step     = (state_q == ST_SCAN) && !blocked;
	assign cmd.finish   = (state_q == ST_FINISH) && (!sts.held_valid || sts.can_push);
	assign cmd.scan_idx = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						if (op == ptd_pkg::OP_TICK) begin
							state_q <= ST_SCAN;
							cnt_q   <= '0;
						end else if (op == ptd_pkg::OP_QUERY) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (cmd.step) begin
						if (cnt_q == ptd_pkg::SCAN_W'(ptd_pkg::NUM_SCAN - 1)) begin
							state_q <= ST_FINISH;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_step_and_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.finish)) else $error("step and finish together");

	a_tick_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && op == ptd_pkg::OP_TICK) |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("tick did not start scan");

	a_blocked_holds_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !cmd.step) |=> $stable(cnt_q))
		else $error("scan moved while blocked");

	a_idle_buffer_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.held_valid)
		else $error("held result left in idle");

endmodule

>>> rtl/ptd_datapath.sv
module ptd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ptd_pkg::ctl_cmd_t                cmd,
	input  logic [ptd_pkg::OP_W-1:0]         op,
	input  logic [ptd_pkg::INDEX_W-1:0]      task_index,
	input  logic [ptd_pkg::TIME_WIDTH-1:0]   period,
	output ptd_pkg::dp_sts_t                 sts,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ptd_pkg::KIND_W-1:0]       kind,
	output logic [ptd_pkg::INDEX_W-1:0]      task_id,
	output logic                             enabled,
	output logic                             last
);

	logic [ptd_pkg::TIME_WIDTH-1:0]      tick_q;
	logic [ptd_pkg::NUM_TIMED_TASKS-1:0] en_q;
	logic [ptd_pkg::TIME_WIDTH-1:0]      period_q [ptd_pkg::NUM_TIMED_TASKS];
	logic [ptd_pkg::TIME_WIDTH-1:0]      due_q    [ptd_pkg::NUM_TIMED_TASKS];
	logic [ptd_pkg::NUM_EVENTS-1:0]      pend_q;

	logic                          held_valid_q;
	logic [ptd_pkg::KIND_W-1:0]    held_kind_q;
	logic [ptd_pkg::INDEX_W-1:0]   held_id_q;
	logic                          held_en_q;
	logic                          out_valid_q;

	logic                          is_task;
	logic [ptd_pkg::TIDX_W-1:0]    tidx;
	logic [ptd_pkg::EIDX_W-1:0]    eidx;
	logic [ptd_pkg::SCAN_W-1:0]    ev_off;
	logic [ptd_pkg::TIME_WIDTH-1:0] next_due;
	logic                          hit;
	logic [ptd_pkg::TIDX_W-1:0]    in_tidx;
	logic [ptd_pkg::EIDX_W-1:0]    in_eidx;
	logic                          in_task_ok;
	logic                          in_event_ok;
	logic                          can_push;
	logic                          push;
	logic                          found;

	assign is_task  = cmd.scan_idx < ptd_pkg::SCAN_W'(ptd_pkg::NUM_TIMED_TASKS);
	assign tidx     = ptd_pkg::TIDX_W'(cmd.scan_idx);
	assign ev_off   = cmd.scan_idx - ptd_pkg::SCAN_W'(ptd_pkg::NUM_TIMED_TASKS);
	assign eidx     = ptd_pkg::EIDX_W'(ev_off);
	assign next_due = tick_q + period_q[tidx];
	assign hit      = is_task ? (en_q[tidx] && (tick_q >= due_q[tidx])) : pend_q[eidx];

	assign in_tidx     = ptd_pkg::TIDX_W'(task_index);
	assign in_eidx     = ptd_pkg::EIDX_W'(task_index);
	assign in_task_ok  = task_index < ptd_pkg::INDEX_W'(ptd_pkg::NUM_TIMED_TASKS);
	assign in_event_ok = task_index < ptd_pkg::INDEX_W'(ptd_pkg::NUM_EVENTS);

	assign can_push = !out_valid_q || !out_stall;
	assign found    = cmd.step && hit;
	assign push     = held_valid_q && (found || cmd.finish);

	assign sts.hit        = hit;
	assign sts.held_valid = held_valid_q;
	assign sts.can_push   = can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			pend_q       <= '0;
			held_valid_q <= 1'b0;
			for (int i = 0; i < ptd_pkg::NUM_TIMED_TASKS; i++) begin
				en_q[i]     <= ptd_pkg::boot_enable(i);
				period_q[i] <= ptd_pkg::boot_period(i);
				due_q[i]    <= '0;
			end
		end else begin
			if (cmd.accept) begin
				unique case (op)
					ptd_pkg::OP_TICK: begin
						tick_q <= tick_q + 1'b1;
					end
					ptd_pkg::OP_ARM: begin
						if (in_task_ok) begin
							en_q[in_tidx]     <= 1'b1;
							period_q[in_tidx] <= period;
							due_q[in_tidx]    <= tick_q + period;
						end
					end
					ptd_pkg::OP_DISARM: begin
						if (in_task_ok) begin
							en_q[in_tidx] <= 1'b0;
						end
					end
					ptd_pkg::OP_QUERY: begin
						held_valid_q <= 1'b1;
					end
					ptd_pkg::OP_RAISE: begin
						if (in_event_ok) begin
							pend_q[in_eidx] <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (found) begin
				held_valid_q <= 1'b1;
				if (is_task) begin
					due_q[tidx] <= next_due;
				end else begin
					pend_q[eidx] <= 1'b0;
				end
			end
			if (cmd.finish) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	// held result payload
	always_ff @(posedge clk) begin
		if (cmd.accept && op == ptd_pkg::OP_QUERY) begin
			held_kind_q <= ptd_pkg::KIND_QUERY;
			held_id_q   <= task_index;
			held_en_q   <= in_task_ok && en_q[in_tidx];
		end else if (found) begin
			held_en_q <= 1'b0;
			if (is_task) begin
				held_kind_q <= ptd_pkg::KIND_TASK;
				held_id_q   <= ptd_pkg::INDEX_W'(cmd.scan_idx);
			end else begin
				held_kind_q <= ptd_pkg::KIND_EVENT;
				held_id_q   <= ptd_pkg::INDEX_W'(ev_off);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind    <= held_kind_q;
			task_id <= held_id_q;
			enabled <= held_en_q;
			last    <= cmd.finish;
		end
	end

	assign out_valid = out_valid_q;

endmodule
